@@ rtl/rsi_pkg.sv @@
// ============================================================================
// rsi_pkg - shared types and widths for the ray/sphere intersection pipeline
// Fixed field widths of the word, the internal fixed-point widths that follow
// from them, and the sideband struct that travels beside the square root.
// ============================================================================
package rsi_pkg;

    // Word field widths
    localparam int COORD_W = 32;    // Q15.16 signed coordinates
    localparam int DIR_W   = 18;    // Q1.16 signed direction
    localparam int RAD_W   = 31;    // Q15.16 unsigned radius
    localparam int DIST_W  = 32;    // Q16.16 unsigned distance
    localparam int FRAC_W  = 16;    // fraction bits of the word fields
    localparam int SCALE_W = 2 * FRAC_W;    // Q.32 to Q.64 alignment

    // Internal widths
    localparam int V_W     = COORD_W + 1;           // origin - center
    localparam int PROD_W  = V_W + DIR_W;           // v * dir
    localparam int SQ_W    = 2 * V_W - 1;           // |v|^2, |v| <= 2^32
    localparam int RR_W    = 2 * RAD_W;             // radius^2
    localparam int A_W     = 52;                    // sum of three v * dir
    localparam int AMAG_W  = A_W - 1;               // |a| < 2^51
    localparam int ALO_W   = 26;                    // low part of |a|
    localparam int AHI_W   = AMAG_W - ALO_W;        // high part of |a|
    localparam int VV_W    = SQ_W + 1;              // sum of three squares
    localparam int A2_W    = 2 * AMAG_W;            // a^2
    localparam int POS_W   = A2_W + 1;              // a^2 + r^2 << 32
    localparam int DISC_W  = POS_W + 1;             // signed difference
    localparam int ROOT_W  = DISC_W / 2;            // square root bits
    localparam int REM_W   = ROOT_W + 2;            // root remainder
    localparam int T_W     = ROOT_W + 2;            // -a - root, signed

    // Sideband carried alongside the root
    typedef struct packed {
        logic                  hit;
        logic signed [A_W-1:0] a;
    } t_rsi_side;

endpackage

@@ rtl/rsi_sqrt_pipe.sv @@
// ============================================================================
// rsi_sqrt_pipe - pipelined integer square root
// Restoring square root, one root bit per register stage, most significant
// bit first. A sideband struct and a valid bit travel with each word; all
// stages advance together on i_en.
// ============================================================================
module rsi_sqrt_pipe
    import rsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DISC_W-1:0] i_disc,
    input  t_rsi_side         i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_rsi_side         o_side
);

    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [DISC_W-1:0] r_disc [ROOT_W];
    t_rsi_side         r_side [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;

        logic              s_vld;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [DISC_W-1:0] s_disc;
        t_rsi_side         s_side;
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;
        logic [REM_W:0]    w_diff;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        // Select the previous stage, or the pipe input for the first one
        if (k == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_disc = i_disc;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_disc = r_disc[k-1];
            assign s_side = r_side[k-1];
        end

        // Bring down two bits and try the next root bit
        always_comb begin
            w_cur   = {s_rem[REM_W-3:0], s_disc[2*BIT+1 -: 2]};
            w_trial = {s_root, 2'b01};
            w_diff  = {1'b0, w_cur} - {1'b0, w_trial};
            if (!w_diff[REM_W]) begin
                n_rem  = w_diff[REM_W-1:0];
                n_root = {s_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_cur;
                n_root = {s_root[ROOT_W-2:0], 1'b0};
            end
        end

        // Advance the valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        // Advance the payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_disc[k] <= s_disc;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

@@ rtl/ray_sphere_intersect_top.sv @@
// ============================================================================
// ray_sphere_intersect_top - ray/sphere hit test with entry distance
// Fixed-point pipeline: difference vector, dot products, discriminant,
// pipelined square root, clamp and saturate, then an output register with a
// one-word skid stage.
// ============================================================================
// One ray/sphere word is accepted per cycle while o_stall is low, and one
// result word leaves for each, in order. Each passes seven stages for the
// vector math and discriminant, 52 stages of the square root
// (one root bit per stage), and the output register. The square root chain
// sets the latency; throughput is one word per cycle while the output side
// takes results. o_stall rises only after a result has been held back by
// i_stall, and then the whole pipeline holds until the skid stage drains.
module ray_sphere_intersect_top
    import rsi_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_origin_x,
    input  logic signed [COORD_W-1:0] i_origin_y,
    input  logic signed [COORD_W-1:0] i_origin_z,
    input  logic signed [DIR_W-1:0]   i_dir_x,
    input  logic signed [DIR_W-1:0]   i_dir_y,
    input  logic signed [DIR_W-1:0]   i_dir_z,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [RAD_W-1:0]          i_sphere_radius,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_hit,
    output logic [DIST_W-1:0]         o_distance
);

    logic en;

    logic signed [COORD_W-1:0] w_org [3];
    logic signed [COORD_W-1:0] w_ctr [3];
    logic signed [DIR_W-1:0]   w_dir [3];

    // Stage 1: difference vector
    logic                    r1_vld;
    logic signed [V_W-1:0]   r1_v [3];
    logic signed [V_W-1:0]   n1_v [3];
    logic signed [DIR_W-1:0] r1_d [3];
    logic [RAD_W-1:0]        r1_rad;

    // Stage 2: products
    logic                     r2_vld;
    logic signed [PROD_W-1:0] r2_p [3];
    logic signed [PROD_W-1:0] n2_p [3];
    logic [V_W-1:0]           w_vmag [3];
    logic [2*V_W-1:0]         w_sq_full [3];
    logic [SQ_W-1:0]          r2_sq [3];
    logic [SQ_W-1:0]          n2_sq [3];
    logic [RR_W-1:0]          r2_rr;
    logic [RR_W-1:0]          n2_rr;

    // Stage 3: sums
    logic                  r3_vld;
    logic signed [A_W-1:0] r3_a;
    logic signed [A_W-1:0] n3_a;
    logic [VV_W-1:0]       r3_vv;
    logic [VV_W-1:0]       n3_vv;
    logic [RR_W-1:0]       r3_rr;

    // Stage 4: early miss and partial products of a^2
    logic                     r4_vld;
    logic [A_W-1:0]           w_amag_full;
    logic [AHI_W-1:0]         w_ahi;
    logic [ALO_W-1:0]         w_alo;
    logic                     r4_miss;
    logic                     n4_miss;
    logic [2*AHI_W-1:0]       r4_ahh;
    logic [2*AHI_W-1:0]       n4_ahh;
    logic [AHI_W+ALO_W-1:0]   r4_ahl;
    logic [AHI_W+ALO_W-1:0]   n4_ahl;
    logic [2*ALO_W-1:0]       r4_all;
    logic [2*ALO_W-1:0]       n4_all;
    logic signed [A_W-1:0]    r4_a;
    logic [VV_W-1:0]          r4_vv;
    logic [RR_W-1:0]          r4_rr;

    // Stage 5: a^2
    logic                  r5_vld;
    logic [A2_W-1:0]       r5_a2;
    logic [A2_W-1:0]       n5_a2;
    logic                  r5_miss;
    logic signed [A_W-1:0] r5_a;
    logic [VV_W-1:0]       r5_vv;
    logic [RR_W-1:0]       r5_rr;

    // Stage 6: a^2 + r^2
    logic                  r6_vld;
    logic [POS_W-1:0]      r6_pos;
    logic [POS_W-1:0]      n6_pos;
    logic                  r6_miss;
    logic signed [A_W-1:0] r6_a;
    logic [VV_W-1:0]       r6_vv;

    // Stage 7: discriminant
    logic              r7_vld;
    logic [DISC_W-1:0] w_diff;
    logic [DISC_W-1:0] r7_disc;
    logic [DISC_W-1:0] n7_disc;
    t_rsi_side         r7_side;
    t_rsi_side         n7_side;

    // Square root output and final distance
    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_root;
    t_rsi_side         w_side;
    logic [T_W-1:0]    w_t;
    logic [DIST_W-1:0] w_dist;
    logic              w_fin_vld;

    // Output register and skid stage
    logic              w_take;
    logic              r_out_vld;
    logic              n_out_vld;
    logic              r_out_hit;
    logic              n_out_hit;
    logic [DIST_W-1:0] r_out_dist;
    logic [DIST_W-1:0] n_out_dist;
    logic              r_skid_vld;
    logic              n_skid_vld;
    logic              r_skid_hit;
    logic              n_skid_hit;
    logic [DIST_W-1:0] r_skid_dist;
    logic [DIST_W-1:0] n_skid_dist;

    // Advance the pipeline whenever the skid stage is empty
    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_ctr[0] = i_center_x;
    assign w_ctr[1] = i_center_y;
    assign w_ctr[2] = i_center_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    // Advance all pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    // Stage 1: take origin minus center
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n1_v[c] = {w_org[c][COORD_W-1], w_org[c]} - {w_ctr[c][COORD_W-1], w_ctr[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r1_v[c] <= n1_v[c];
                r1_d[c] <= w_dir[c];
            end
            r1_rad <= i_sphere_radius;
        end
    end

    // Stage 2: multiply v by dir, square |v|, square the radius
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n2_p[c]      = r1_v[c] * r1_d[c];
            w_vmag[c]    = r1_v[c][V_W-1] ? (~r1_v[c] + 1'b1) : r1_v[c];
            w_sq_full[c] = w_vmag[c] * w_vmag[c];
            n2_sq[c]     = w_sq_full[c][SQ_W-1:0];
        end
        n2_rr = r1_rad * r1_rad;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r2_p[c]  <= n2_p[c];
                r2_sq[c] <= n2_sq[c];
            end
            r2_rr <= n2_rr;
        end
    end

    // Stage 3: sum the dot product and the squared length
    always_comb begin
        n3_a  = '0;
        n3_vv = '0;
        for (int c = 0; c < 3; c++) begin
            n3_a  = n3_a + {{(A_W-PROD_W){r2_p[c][PROD_W-1]}}, r2_p[c]};
            n3_vv = n3_vv + {{(VV_W-SQ_W){1'b0}}, r2_sq[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_a  <= n3_a;
            r3_vv <= n3_vv;
            r3_rr <= r2_rr;
        end
    end

    // Stage 4: flag outside-and-pointing-away, split |a| for squaring
    always_comb begin
        w_amag_full = r3_a[A_W-1] ? (~r3_a + 1'b1) : r3_a;
        w_ahi       = w_amag_full[AMAG_W-1:ALO_W];
        w_alo       = w_amag_full[ALO_W-1:0];
        n4_miss     = (r3_vv > {{(VV_W-RR_W){1'b0}}, r3_rr})
                      && !r3_a[A_W-1] && (r3_a != '0);
        n4_ahh      = w_ahi * w_ahi;
        n4_ahl      = w_ahi * w_alo;
        n4_all      = w_alo * w_alo;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_miss <= n4_miss;
            r4_ahh  <= n4_ahh;
            r4_ahl  <= n4_ahl;
            r4_all  <= n4_all;
            r4_a    <= r3_a;
            r4_vv   <= r3_vv;
            r4_rr   <= r3_rr;
        end
    end

    // Stage 5: combine partial products into a^2
    assign n5_a2 = {r4_ahh, {(2*ALO_W){1'b0}}}
                 + {{(A2_W-AHI_W-2*ALO_W-1){1'b0}}, r4_ahl, {(ALO_W+1){1'b0}}}
                 + {{(A2_W-2*ALO_W){1'b0}}, r4_all};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_a2   <= n5_a2;
            r5_miss <= r4_miss;
            r5_a    <= r4_a;
            r5_vv   <= r4_vv;
            r5_rr   <= r4_rr;
        end
    end

    // Stage 6: add the aligned radius square
    assign n6_pos = {1'b0, r5_a2} + {{(POS_W-RR_W-SCALE_W){1'b0}}, r5_rr, {SCALE_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pos  <= n6_pos;
            r6_miss <= r5_miss;
            r6_a    <= r5_a;
            r6_vv   <= r5_vv;
        end
    end

    // Stage 7: subtract the aligned squared length, negative means miss
    always_comb begin
        w_diff      = {1'b0, r6_pos} - {{(DISC_W-VV_W-SCALE_W){1'b0}}, r6_vv, {SCALE_W{1'b0}}};
        n7_disc     = {1'b0, w_diff[DISC_W-2:0]};
        n7_side.hit = !r6_miss && !w_diff[DISC_W-1];
        n7_side.a   = r6_a;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_disc <= n7_disc;
            r7_side <= n7_side;
        end
    end

    rsi_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_vld),
        .i_disc  (r7_disc),
        .i_side  (r7_side),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    // Form -a - root, clamp at zero, drop fraction bits, saturate
    always_comb begin
        w_t = '0 - {{(T_W-A_W){w_side.a[A_W-1]}}, w_side.a}
                 - {{(T_W-ROOT_W){1'b0}}, w_root};
        if (!w_side.hit || w_t[T_W-1]) begin
            w_dist = '0;
        end else if (|w_t[T_W-2:FRAC_W+DIST_W]) begin
            w_dist = '1;
        end else begin
            w_dist = w_t[FRAC_W+DIST_W-1:FRAC_W];
        end
    end

    assign w_fin_vld = w_sq_vld && en;
    assign w_take    = r_out_vld && !i_stall;

    // Load the output register from skid or pipe, park in skid when held
    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_hit   = r_out_hit;
        n_out_dist  = r_out_dist;
        n_skid_vld  = r_skid_vld;
        n_skid_hit  = r_skid_hit;
        n_skid_dist = r_skid_dist;
        if (!r_out_vld || w_take) begin
            if (r_skid_vld) begin
                n_out_vld  = 1'b1;
                n_out_hit  = r_skid_hit;
                n_out_dist = r_skid_dist;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld  = w_fin_vld;
                n_out_hit  = w_side.hit;
                n_out_dist = w_dist;
            end
        end else if (w_fin_vld) begin
            n_skid_vld  = 1'b1;
            n_skid_hit  = w_side.hit;
            n_skid_dist = w_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit   <= n_out_hit;
        r_out_dist  <= n_out_dist;
        r_skid_hit  <= n_skid_hit;
        r_skid_dist <= n_skid_dist;
    end

    assign o_valid    = r_out_vld;
    assign o_hit      = r_out_hit;
    assign o_distance = r_out_dist;

endmodule

@@ rtl/rsi_checker.sv @@
// ============================================================================
// rsi_checker - port-level checks for ray_sphere_intersect_top
// Watches the handshake and result ports over time; attached by bind.
// ============================================================================
module rsi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_hit,
    input logic [31:0] o_distance
);

    // A held result word keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_distance))
        else $error("result word changed while stalled");

    // A miss reports zero distance
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_distance == 32'd0)
        else $error("miss with nonzero distance");

    // Input backpressure only while a result word is waiting
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // Backpressure starts only after the output was held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without output stall");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

endmodule

bind ray_sphere_intersect_top rsi_checker u_rsi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_hit      (o_hit),
    .o_distance (o_distance)
);
